// ===== hw/rtl/x86alu_pkg.sv =====
// ---------------------------------------------------------------------------
// x86alu_pkg: shared types and constants of the x86 integer ALU
// Operation codes, operand size codes, the flag set and mask helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package x86alu_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBB  = 5'd3;
    localparam logic [4:0] OP_MUL  = 5'd4;
    localparam logic [4:0] OP_IMUL = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_IDIV = 5'd7;
    localparam logic [4:0] OP_MOD  = 5'd8;
    localparam logic [4:0] OP_IMOD = 5'd9;
    localparam logic [4:0] OP_AND  = 5'd10;
    localparam logic [4:0] OP_OR   = 5'd11;
    localparam logic [4:0] OP_XOR  = 5'd12;
    localparam logic [4:0] OP_SHL  = 5'd13;
    localparam logic [4:0] OP_SAL  = 5'd14;
    localparam logic [4:0] OP_SHR  = 5'd15;
    localparam logic [4:0] OP_SAR  = 5'd16;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    typedef struct packed {
        logic cf;
        logic pf;
        logic zf;
        logic sf;
        logic of;
    } flags_t;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end
        else begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic top_bit(input logic [63:0] v, input logic [6:0] n);
        logic [63:0] t;
        t = v >> (n - 7'd1);
        return t[0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/x86_integer_alu_flags.sv =====
// ---------------------------------------------------------------------------
// x86_integer_alu_flags: x86 integer ALU with CF, PF, ZF, SF and OF
// Executes one add, logic, shift, multiply or divide request per item.
// ---------------------------------------------------------------------------
// Usage: a request enters on in_valid/in_ready with req_type, operand_size
// and the three operands; the result leaves on out_valid/out_ready as the
// masked value, the five flags after the operation and divide_error.
// Add, subtract, logic, shift and unknown codes need no iteration: the result
// is registered at the edge that accepts the request.
// Multiply runs one bit of the multiplier per cycle, divide one quotient
// bit per cycle, both over the operand size (8, 16 or 32 bits). The result
// is registered in ST_DONE once the output register is free, and the next
// request may enter after the block has returned to ST_IDLE.
// A divide by zero or an early quotient overflow skips the iteration and
// goes straight to ST_DONE.
// One request is worked on at a time. A new request enters only when the
// output register is empty or is being emptied in the same cycle; a
// stalled receiver holds a finished multiply or divide in its last state.
// Reset clears all flags and empties the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86_integer_alu_flags
    import x86alu_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [4:0]  req_type,
    input  wire logic [1:0]  operand_size,
    input  wire logic [31:0] source_operand,
    input  wire logic [31:0] dest_operand,
    input  wire logic [31:0] dividend_high,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      result_value,
    output logic             carry_flag,
    output logic             parity_flag,
    output logic             zero_flag,
    output logic             sign_flag,
    output logic             overflow_flag,
    output logic             divide_error
);

    localparam int WIDE_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

    state_t      state_reg;
    flags_t      flags_reg;
    logic        out_valid_reg;
    logic [63:0] result_reg;
    logic        derr_reg;
    logic [4:0]  op_reg;
    logic [6:0]  n_reg;
    logic [5:0]  count_reg;
    logic        neg_reg;
    logic        sa_reg;
    logic        err_reg;
    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [31:0] rem_reg;
    logic [31:0] dq_reg;

    logic        accept;
    logic        out_free;
    logic        out_load;
    logic [6:0]  n;
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] d;
    logic [4:0]  cnt;
    logic        cin;
    logic [63:0] r;
    logic [63:0] res;
    logic [63:0] w;
    logic [63:0] sx;
    logic [63:0] sh;
    flags_t      fl;
    logic        sgn_s;
    logic        sgn_d;
    logic [63:0] mag_s;
    logic [63:0] mag_d;
    logic [63:0] dv;
    logic [63:0] a;
    logic        sa;
    logic [63:0] ahigh;
    logic        div_signed;
    logic        early_err;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [63:0] p;
    logic [63:0] phi;
    logic [63:0] m1;
    logic [63:0] q;
    logic [63:0] lim;
    logic        ferr;
    logic [63:0] fres;
    flags_t      ffl;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_load  = (accept && !((req_type >= OP_MUL) && (req_type <= OP_IMOD)))
                       || ((state_reg == ST_DONE) && out_free);
    assign out_valid = out_valid_reg;
    assign result_value  = result_reg;
    assign carry_flag    = flags_reg.cf;
    assign parity_flag   = flags_reg.pf;
    assign zero_flag     = flags_reg.zf;
    assign sign_flag     = flags_reg.sf;
    assign overflow_flag = flags_reg.of;
    assign divide_error  = derr_reg;

    always_comb
    begin
        unique case (operand_size)
            SIZE_BYTE: n = 7'd8;
            SIZE_WORD: n = 7'd16;
            default:   n = 7'(WIDE_BITS);
        endcase
        m   = low_mask(n);
        s   = {32'd0, source_operand} & m;
        d   = {32'd0, dest_operand} & m;
        cnt = source_operand[4:0];
        cin = ((req_type == OP_ADC) || (req_type == OP_SBB)) && flags_reg.cf;
        r   = '0;
        res = '0;
        w   = '0;
        sx  = '0;
        sh  = '0;
        fl  = flags_reg;
        unique case (req_type)
            OP_ADD, OP_ADC:
            begin
                r = d + s + {63'd0, cin};
                res = r & m;
                fl.cf = top_bit(r, n + 7'd1);
                fl.of = top_bit((d ^ res) & (s ^ res), n);
            end
            OP_SUB, OP_SBB:
            begin
                r = s + {63'd0, cin};
                res = (d - r) & m;
                fl.cf = d < r;
                fl.of = top_bit((d ^ s) & (d ^ res), n);
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                if (req_type == OP_AND) begin
                    res = s & d;
                end
                else if (req_type == OP_OR) begin
                    res = s | d;
                end
                else begin
                    res = s ^ d;
                end
                fl.cf = 1'b0;
                fl.of = 1'b0;
            end
            OP_SHL, OP_SAL:
            begin
                w = d << cnt;
                res = (cnt == 5'd0) ? d : (w & m);
                fl.cf = top_bit(w, n + 7'd1);
                fl.of = top_bit(res, n) != fl.cf;
            end
            OP_SHR:
            begin
                res = d >> cnt;
                w = d >> (cnt - 5'd1);
                fl.cf = w[0];
                fl.of = top_bit(d, n);
            end
            OP_SAR:
            begin
                sx = top_bit(d, n) ? (d | ~m) : d;
                sh = 64'($signed(sx) >>> cnt);
                res = sh & m;
                w = sx >> (cnt - 5'd1);
                fl.cf = w[0];
                fl.of = 1'b0;
            end
            default:
            begin
                res = '0;
            end
        endcase
        if ((req_type != OP_AND) && (req_type != OP_OR) && (req_type != OP_XOR)
            && !((req_type >= OP_SHL) && (req_type <= OP_SAR) && (cnt == 5'd1))) begin
            fl.of = ((req_type <= OP_SBB)) ? fl.of : flags_reg.of;
        end
        if ((req_type <= OP_SBB) || ((req_type >= OP_AND) && (req_type <= OP_SAR))) begin
            fl.pf = ~^res[7:0];
            fl.zf = (res & m) == 64'd0;
            fl.sf = top_bit(res, n);
        end
        if (((req_type >= OP_SHL) && (req_type <= OP_SAR)) && (cnt == 5'd0)) begin
            fl  = flags_reg;
            res = d;
        end
        if (req_type > OP_SAR) begin
            fl = flags_reg;
        end
    end

    always_comb
    begin
        sgn_s = top_bit(s, n);
        sgn_d = top_bit(d, n);
        mag_s = (sgn_s && (req_type == OP_IMUL)) ? ((~s + 64'd1) & m) : s;
        mag_d = (sgn_d && (req_type == OP_IMUL)) ? ((~d + 64'd1) & m) : d;
        div_signed = (req_type == OP_IDIV) || (req_type == OP_IMOD);
        dv = (({32'd0, dividend_high} & m) << n) | d;
        sa = div_signed && top_bit(dv, n << 1);
        a  = sa ? ((~dv + 64'd1) & low_mask(n << 1)) : dv;
        ahigh = a >> n;
        early_err = (s == 64'd0) || (ahigh >= (div_signed && sgn_s ?
                    ((~s + 64'd1) & m) : s));
    end

    always_comb
    begin
        trial = {rem_reg, dq_reg[31]};
        diff  = trial - {1'b0, mcand_reg[31:0]};
    end

    always_comb
    begin
        ffl  = flags_reg;
        ferr = 1'b0;
        fres = '0;
        m1   = low_mask(n_reg + 7'd1);
        p    = (neg_reg ? (~acc_reg + 64'd1) : acc_reg) & low_mask(n_reg << 1);
        phi  = (p >> (n_reg - 7'd1)) & m1;
        q    = {32'd0, dq_reg} & low_mask(n_reg);
        lim  = 64'd1 << (n_reg - 7'd1);
        if ((op_reg == OP_MUL) || (op_reg == OP_IMUL)) begin
            fres = p;
            if (op_reg == OP_MUL) begin
                ffl.cf = (p >> n_reg) != 64'd0;
            end
            else begin
                ffl.cf = !((phi == 64'd0) || (phi == m1));
            end
            ffl.of = ffl.cf;
        end
        else begin
            ferr = err_reg;
            if (!err_reg && ((op_reg == OP_IDIV) || (op_reg == OP_IMOD))) begin
                ferr = neg_reg ? (q > lim) : (q > lim - 64'd1);
            end
            if (!ferr) begin
                if ((op_reg == OP_MOD) || (op_reg == OP_IMOD)) begin
                    fres = sa_reg ? ((~{32'd0, rem_reg} + 64'd1) & low_mask(n_reg))
                                  : {32'd0, rem_reg};
                end
                else begin
                    fres = neg_reg ? ((~q + 64'd1) & low_mask(n_reg)) : q;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (out_valid_reg && out_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept) begin
                        op_reg <= req_type;
                        n_reg  <= n;
                        count_reg <= n[5:0];
                        if ((req_type == OP_MUL) || (req_type == OP_IMUL)) begin
                            neg_reg    <= (req_type == OP_IMUL) && (sgn_s != sgn_d);
                            acc_reg    <= '0;
                            mcand_reg  <= mag_d;
                            mplier_reg <= mag_s[31:0];
                            state_reg  <= ST_MUL;
                        end
                        else if ((req_type >= OP_DIV) && (req_type <= OP_IMOD)) begin
                            neg_reg   <= div_signed && (sa != sgn_s);
                            sa_reg    <= sa;
                            err_reg   <= early_err;
                            mcand_reg <= (div_signed && sgn_s) ? ((~s + 64'd1) & m) : s;
                            rem_reg   <= ahigh[31:0];
                            dq_reg    <= 32'((a & m) << (7'd32 - n));
                            state_reg <= early_err ? ST_DONE : ST_DIV;
                        end
                        else begin
                            result_reg    <= res;
                            derr_reg      <= 1'b0;
                            flags_reg     <= fl;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    count_reg  <= count_reg - 6'd1;
                    if (count_reg == 6'd1) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DIV:
                begin
                    if (!diff[32]) begin
                        rem_reg <= diff[31:0];
                    end
                    else begin
                        rem_reg <= trial[31:0];
                    end
                    dq_reg    <= {dq_reg[30:0], !diff[32]};
                    count_reg <= count_reg - 6'd1;
                    if (count_reg == 6'd1) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free) begin
                        result_reg    <= fres;
                        derr_reg      <= ferr;
                        flags_reg     <= ffl;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
